>>> design/ppc_pkg.sv
// Package for the PID/PWM controller: field widths, register indexes,
// reset values and pipeline word sizes. No dependencies.
package ppc_pkg;

    localparam int SETPOINT_W = 15;
    localparam int MEASURED_W = 15;
    localparam int DUTY_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Signed working widths
    localparam int ERR_W  = 16;   // setpoint - measured
    localparam int SUM_W  = 16;   // clamped error sum
    localparam int DIFF_W = 17;   // error - last error
    localparam int ACC_W  = 36;   // sum of the three gain products

    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd256;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd0;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd0;
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 15'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 2'd0,
        CFG_INTEG_GAIN  = 2'd1,
        CFG_DERIV_GAIN  = 2'd2,
        CFG_INTEG_LIMIT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_STEP  = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

endpackage

>>> design/ppc_step_if.sv
// Input channel of the PID/PWM controller: one controller step or clear.
// Depends on ppc_pkg for field widths.
interface ppc_step_if;
    import ppc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [SETPOINT_W-1:0] setpoint;
    logic [MEASURED_W-1:0] measured;

    modport source (output valid, action, setpoint, measured, input ready);
    modport sink   (input valid, action, setpoint, measured, output ready);
endinterface

>>> design/ppc_duty_if.sv
// Result channel of the PID/PWM controller: one PWM duty value.
// Depends on ppc_pkg for the field width.
interface ppc_duty_if;
    import ppc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;

    modport source (output valid, duty, input ready);
    modport sink   (input valid, duty, output ready);
endinterface

>>> design/pid_pwm_controller_unit.sv
// PID controller with clamped integrator and saturated 8-bit PWM duty output.
// A step result passes through the input register, then the result register, after the step
// transaction is accepted.
// Throughput: one transaction per cycle unless result.ready stalls; a register holds only while the next is full.
// Reset (rst_n low, async): error sum and last error cleared, gains and limit to defaults, pipe empty.
// Depends on ppc_pkg, ppc_step_if and ppc_duty_if.
module pid_pwm_controller_unit #(
    parameter int GAIN_FRAC_BITS = ppc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ppc_step_if.sink                       step,
    ppc_duty_if.source                     result,
    input  logic                           cfg_wr_en,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integ_gain_reg;
    logic [GAIN_W-1:0]  deriv_gain_reg;
    logic [LIMIT_W-1:0] integ_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            deriv_gain_reg  <= DERIV_GAIN_RST;
            integ_limit_reg <= INTEG_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The input register advances when the result register
    // is empty or moving, so bubbles collapse and the result register
    // parts the result channel from the step channel.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;

    logic out_go;   // result register may load
    logic s1_go;    // input register may load (step channel ready)
    logic step_acc; // step transaction this cycle

    assign out_go   = !out_valid_reg || result.ready;
    assign s1_go    = !s1_valid_reg || out_go;
    assign step.ready = s1_go;
    assign step_acc = step.valid && s1_go;

    // ------------------------------------------------------------------
    // Accept: error, clamped integrator and difference. The controller
    // state is registered here so the next accepted transaction sees it.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [SUM_W-1:0]  error_sum_next;
    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [ERR_W-1:0]  last_error_next;

    logic signed [ERR_W-1:0]  err_c;
    logic signed [SUM_W:0]    sum_raw_c;
    logic signed [SUM_W:0]    lim_pos_c;
    logic signed [SUM_W:0]    lim_neg_c;
    logic signed [SUM_W-1:0]  sum_clamped_c;
    logic signed [DIFF_W-1:0] diff_c;

    always_comb
    begin
        err_c     = signed'({1'b0, step.setpoint}) - signed'({1'b0, step.measured});
        sum_raw_c = signed'({error_sum_reg[SUM_W-1], error_sum_reg})
                    + signed'({err_c[ERR_W-1], err_c});
        lim_pos_c = signed'({2'b00, integ_limit_reg});
        lim_neg_c = -lim_pos_c;
        // Clamp to the configured symmetric limit; the clamped value is kept.
        priority if (sum_raw_c > lim_pos_c)
            sum_clamped_c = lim_pos_c[SUM_W-1:0];
        else if (sum_raw_c < lim_neg_c)
            sum_clamped_c = lim_neg_c[SUM_W-1:0];
        else
            sum_clamped_c = sum_raw_c[SUM_W-1:0];
        diff_c = {err_c[ERR_W-1], err_c} - {last_error_reg[ERR_W-1], last_error_reg};
    end

    always_comb
    begin
        error_sum_next  = error_sum_reg;
        last_error_next = last_error_reg;
        if (step_acc)
        begin
            unique case (action_t'(step.action))
                ACT_CLEAR:
                begin
                    // Drop the integral; last error holds.
                    error_sum_next = '0;
                end
                ACT_STEP:
                begin
                    error_sum_next  = sum_clamped_c;
                    last_error_next = err_c;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= last_error_next;
        end
    end

    // Input register: terms waiting for the multipliers.
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_go)
            s1_valid_reg <= step.valid && (step.action == ACT_STEP);
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s1_err_reg  <= err_c;
            s1_sum_reg  <= sum_clamped_c;
            s1_diff_reg <= diff_c;
        end
    end

    // ------------------------------------------------------------------
    // Three independent gain products, gains zero-extended, then add,
    // drop the fraction and saturate to 0..255.
    // ------------------------------------------------------------------
    localparam int P_W = GAIN_W + 1 + ERR_W;
    localparam int I_W = GAIN_W + 1 + SUM_W;
    localparam int D_W = GAIN_W + 1 + DIFF_W;

    logic signed [P_W-1:0]   prop_c;
    logic signed [I_W-1:0]   integ_c;
    logic signed [D_W-1:0]   deriv_c;
    logic signed [ACC_W-1:0] acc_c;
    logic                    over_c;
    logic [DUTY_W-1:0]       duty_c;
    logic [DUTY_W-1:0]       duty_reg;

    always_comb
    begin
        prop_c  = signed'({1'b0, prop_gain_reg})  * s1_err_reg;
        integ_c = signed'({1'b0, integ_gain_reg}) * s1_sum_reg;
        deriv_c = signed'({1'b0, deriv_gain_reg}) * s1_diff_reg;
        acc_c   = ACC_W'(prop_c) + ACC_W'(integ_c) + ACC_W'(deriv_c);
        // Any magnitude bit above the duty field means saturation.
        over_c = |acc_c[ACC_W-2:GAIN_FRAC_BITS+DUTY_W];
        priority if (acc_c[ACC_W-1])
            duty_c = '0;
        else if (over_c)
            duty_c = '1;
        else
            duty_c = acc_c[GAIN_FRAC_BITS+DUTY_W-1:GAIN_FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_go)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_go)
            duty_reg <= duty_c;
    end

    assign result.valid = out_valid_reg;
    assign result.duty  = duty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_sum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (step_acc && step.action == ACT_STEP && !cfg_wr_en) |=>
        (error_sum_reg <= signed'({1'b0, integ_limit_reg}) &&
         error_sum_reg >= -signed'({1'b0, integ_limit_reg})))
        else $error("error sum outside integrator limit after a step");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (step_acc && step.action == ACT_CLEAR) |=> (error_sum_reg == '0))
        else $error("clear transaction did not zero the error sum");

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step_acc && step.action == ACT_CLEAR) |=> !s1_valid_reg)
        else $error("clear transaction entered the result pipeline");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |=>
        (s1_valid_reg && $stable(s1_err_reg) && $stable(s1_sum_reg)
         && $stable(s1_diff_reg)))
        else $error("input register terms lost while output stalled");

endmodule
